>>> rtl/see_pkg.sv
package see_pkg;

    // Default sizes of the operand stack.
    localparam int DEPTH_DEFAULT = 64;
    localparam int WIDTH_DEFAULT = 32;

    // Stream and register port widths.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index of the notation mode register.
    localparam logic REG_NOTATION_MODE = 1'b0;

    // Token kinds carried on tuser.
    localparam logic KIND_DIGIT    = 1'b0;
    localparam logic KIND_OPERATOR = 1'b1;

    // Operator codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes of a result word.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Request from the core to the iterative multiply and divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } alu_ctrl_t;

endpackage

>>> rtl/see_alu.sv
// Iterative multiply and signed divide unit, one bit per cycle.
module see_alu #(
    parameter int WIDTH = see_pkg::WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  see_pkg::alu_ctrl_t ctrl,
    input  logic [WIDTH-1:0]   opa,
    input  logic [WIDTH-1:0]   opb,
    output logic               done,
    output logic [WIDTH-1:0]   result
);

    localparam int STEP_W = $clog2(WIDTH);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              div_reg;
    logic              neg_reg;
    logic [WIDTH-1:0]  acc_reg;
    logic [WIDTH-1:0]  x_reg;
    logic [WIDTH-1:0]  y_reg;

    logic [WIDTH:0]    rem_shift;
    logic [WIDTH:0]    rem_diff;
    logic [WIDTH-1:0]  mag_a;
    logic [WIDTH-1:0]  mag_b;

    assign mag_a     = opa[WIDTH-1] ? (~opa + 1'b1) : opa;
    assign mag_b     = opb[WIDTH-1] ? (~opb + 1'b1) : opb;
    assign rem_shift = {acc_reg, x_reg[WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            div_reg <= ctrl.is_div;
            neg_reg <= opa[WIDTH-1] ^ opb[WIDTH-1];
            acc_reg <= '0;
            x_reg   <= ctrl.is_div ? mag_a : opa;
            y_reg   <= ctrl.is_div ? mag_b : opb;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // Restoring division: shift in one dividend bit, subtract if it fits.
                if (!rem_diff[WIDTH])
                begin
                    acc_reg <= rem_diff[WIDTH-1:0];
                    x_reg   <= {x_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= rem_shift[WIDTH-1:0];
                    x_reg   <= {x_reg[WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[WIDTH-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[WIDTH-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~x_reg + 1'b1) : x_reg) : acc_reg;

endmodule

>>> rtl/stack_expression_evaluator_core.sv
// Sequencing: a digit token is pushed from S_IDLE; add and subtract pass through S_READ,
// multiply and divide through S_READ and S_EXEC; a token marked last then reports in S_FIN.
// Throughput: one token at a time; the bit-serial multiply/divide unit sets the worst
// case, and the stack memory read port gives one read per op.
// Reset: rst_n is asynchronous and active low; it empties the stack, clears the error
// code, drops any pending output word and selects postfix notation. Stack memory is
// not cleared.
module stack_expression_evaluator_core #(
    parameter int DEPTH = see_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = see_pkg::WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Token stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [see_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // digit[3:0], op[5:4], zero pad
    input  logic                             s_axis_tuser,  // token_kind
    input  logic                             s_axis_tlast,

    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [see_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // value[31:0], status[34:32], pad

    // Register port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [see_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [see_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [see_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a token
    localparam logic [1:0] S_READ = 2'd1;  // stack entry below the top is on the read port
    localparam logic [1:0] S_EXEC = 2'd2;  // multiply or divide in progress
    localparam logic [1:0] S_FIN  = 2'd3;  // report the expression and clear the stack

    // The top of stack lives in tos_reg; the memory holds entries 0 .. count-2.
    // A push spills the old top into the memory, an operator reads the entry below.
    logic [WIDTH-1:0]           mem [DEPTH];
    logic [WIDTH-1:0]           rd_data_reg;
    logic [CNT_W-1:0]           rd_index;
    logic [CNT_W-1:0]           wr_index;
    logic [IDX_W-1:0]           rd_addr;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;

    logic [1:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [see_pkg::STATUS_W-1:0] err_reg, err_next;
    logic [WIDTH-1:0]           tos_reg, tos_next;
    logic                       mode_reg;
    logic [1:0]                 op_reg, op_next;
    logic                       last_reg, last_next;

    logic                       out_valid_reg, out_valid_next;
    logic [see_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [see_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [WIDTH-1:0]           oper_a;
    logic [WIDTH-1:0]           oper_b;
    logic [WIDTH-1:0]           alu_result;
    logic                       alu_done;
    see_pkg::alu_ctrl_t         alu_ctrl;

    logic [64:0]                tos_ext;
    logic [see_pkg::STATUS_W-1:0] fin_status;
    logic                       cfg_write;

    // Register port: a single one-bit register, always ready.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[see_pkg::CFG_ADDR_W-1:2] == see_pkg::REG_NOTATION_MODE) ?
                       {{(see_pkg::CFG_DATA_W - 1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[see_pkg::CFG_ADDR_W-1:2] == see_pkg::REG_NOTATION_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Stack memory. The read address follows the count, so the entry below the top is
    // captured at the edge that accepts an operator. Writes happen only on a push, at an
    // earlier edge than any read that needs the entry, so no forwarding path is needed.
    assign rd_index  = count_reg - CNT_W'(2);
    assign wr_index  = count_reg - CNT_W'(1);
    assign rd_addr   = rd_index[IDX_W-1:0];
    assign mem_waddr = wr_index[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= tos_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Postfix takes the lower entry as the left operand; prefix swaps the order.
    assign oper_a = mode_reg ? tos_reg : rd_data_reg;
    assign oper_b = mode_reg ? rd_data_reg : tos_reg;

    see_alu #(
        .WIDTH (WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .opa    (oper_a),
        .opb    (oper_b),
        .done   (alu_done),
        .result (alu_result)
    );

    // Result word: the top of stack sign-extended (or truncated) to 32 bits.
    assign tos_ext    = {{(65 - WIDTH){tos_reg[WIDTH-1]}}, tos_reg};
    assign fin_status = ((err_reg == see_pkg::ST_OK) && (count_reg == '0)) ?
                        see_pkg::ST_EMPTY : err_reg;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        alu_ctrl        = '0;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tdata[5:4];
                    last_next  = s_axis_tlast;
                    state_next = s_axis_tlast ? S_FIN : S_IDLE;
                    // After an error every token of the expression is ignored.
                    if (err_reg == see_pkg::ST_OK)
                    begin
                        if (s_axis_tuser == see_pkg::KIND_DIGIT)
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                err_next = see_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = (count_reg != '0);
                                tos_next   = {{(WIDTH - 4){1'b0}}, s_axis_tdata[3:0]};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (count_reg < CNT_W'(2))
                        begin
                            err_next = see_pkg::ST_UNDERFLOW;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                state_next = last_reg ? S_FIN : S_IDLE;
                case (op_reg)
                    see_pkg::OP_ADD:
                    begin
                        tos_next   = oper_a + oper_b;
                        count_next = count_reg - 1'b1;
                    end
                    see_pkg::OP_SUB:
                    begin
                        tos_next   = oper_a - oper_b;
                        count_next = count_reg - 1'b1;
                    end
                    see_pkg::OP_MUL:
                    begin
                        alu_ctrl.start  = 1'b1;
                        alu_ctrl.is_div = 1'b0;
                        state_next      = S_EXEC;
                    end
                    default:
                    begin
                        // A zero divisor leaves the stack as it was.
                        if (oper_b == '0)
                        begin
                            err_next = see_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            alu_ctrl.start  = 1'b1;
                            alu_ctrl.is_div = 1'b1;
                            state_next      = S_EXEC;
                        end
                    end
                endcase
            end

            S_EXEC:
            begin
                if (alu_done)
                begin
                    tos_next   = alu_result;
                    count_next = count_reg - 1'b1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end

            default:
            begin
                // Wait until the output register is free, then report and clear.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_value_next  = (fin_status == see_pkg::ST_OK) ?
                                      tos_ext[see_pkg::VALUE_W-1:0] : '0;
                    count_next      = '0;
                    err_next        = see_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= see_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(see_pkg::M_TDATA_W - see_pkg::VALUE_W - see_pkg::STATUS_W){1'b0}},
                            out_status_reg, out_value_reg};

endmodule

>>> rtl/see_checker.sv
// Port-level checks for the expression evaluator.
module see_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [see_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A waiting result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed or dropped while stalled");

    // Any failing status reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[34:32] != see_pkg::ST_OK) |-> (m_axis_tdata[31:0] == '0))
    else $error("nonzero value with an error status");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:32] <= see_pkg::ST_EMPTY))
    else $error("undefined status code");

    // The last token of an expression always holds off the next token.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("token accepted right after the last token");

    // A new result appears only while the token stream is held off for reporting.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised outside the report step");

endmodule

bind stack_expression_evaluator_core see_checker u_see_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
